>>> sv/assert_macros.svh
// Assertion macros used by the decoder RTL (u2u_decode).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define U2U_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define U2U_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U2U_ASSERT(lbl, prop, msg)
`define U2U_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> sv/u2u_pkg.sv
// Types and constants of the UTF-8 to UTF-16 stream decoder.
`default_nettype none
package u2u_pkg;

  localparam logic [15:0] REPL_WIDE   = 16'hFF1F;
  localparam logic [15:0] REPL_ASCII  = 16'h003F;
  localparam logic [7:0]  CONT_MIN    = 8'h80;
  localparam logic [7:0]  CONT_MAX    = 8'hBF;
  localparam logic [7:0]  LEAD2_MIN   = 8'hC0;
  localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
  localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
  localparam logic [7:0]  NUL_BYTE    = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        malformed;
  } out_item_t;

  // What the decoder hands to the output register for one byte.
  typedef struct packed {
    logic      take;
    logic      has_result;
    out_item_t item;
  } dec_res_t;

endpackage
`default_nettype wire

>>> sv/u2u_in_if.sv
// Byte channel: valid/ready handshake with one UTF-8 byte and an end marker.
`default_nettype none
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface
`default_nettype wire

>>> sv/u2u_out_if.sv
// Code unit channel: valid/ready handshake with one UTF-16 unit and a malformed flag.
`default_nettype none
interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        malformed;

  modport source (output valid, output code_unit, output malformed, input ready);
  modport sink (input valid, input code_unit, input malformed, output ready);
endinterface
`default_nettype wire

>>> sv/utf8_to_utf16_stream_decoder_core.sv
// A byte in the input register is decoded and its code unit loaded into the output
// register that drives out_ch. One byte per cycle while the output register is free.
// A result waiting in the output register does not block bytes that produce nothing.
// Reset (rst_n low, synchronous) empties both registers and returns the decoder to idle.
`default_nettype none
module utf8_to_utf16_stream_decoder_core
  import u2u_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  u2u_in_if.sink    in_ch,
  u2u_out_if.source out_ch
);

  in_item_t  src_item;
  in_item_t  item;
  logic      src_ready;
  logic      item_valid;
  logic      out_free;
  dec_res_t  res;
  out_item_t dst_item;
  logic      dst_valid;

  assign src_item.data_byte     = in_ch.data_byte;
  assign src_item.end_of_string = in_ch.end_of_string;
  assign in_ch.ready            = src_ready;

  u2u_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_valid  (in_ch.valid),
    .src_ready  (src_ready),
    .src_item   (src_item),
    .take       (res.take),
    .item_valid (item_valid),
    .item       (item)
  );

  u2u_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .res        (res)
  );

  u2u_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .dst_ready (out_ch.ready),
    .out_free  (out_free),
    .dst_valid (dst_valid),
    .dst_item  (dst_item)
  );

  assign out_ch.valid     = dst_valid;
  assign out_ch.code_unit = dst_item.code_unit;
  assign out_ch.malformed = dst_item.malformed;

endmodule
`default_nettype wire

>>> sv/u2u_in_stage.sv
// Input register that holds one accepted byte until the decoder takes it.
`default_nettype none
module u2u_in_stage
  import u2u_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     src_valid,
  output logic          src_ready,
  input  wire in_item_t src_item,
  input  wire logic     take,
  output logic          item_valid,
  output in_item_t      item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r, item_nxt;

  // A new byte may enter whenever the register is empty or the held one leaves in the same cycle.
  assign src_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (src_ready) begin
      valid_nxt = src_valid;
      item_nxt  = src_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

>>> sv/u2u_decode.sv
// Sequence state and the decode of one byte into at most one code unit.
`default_nettype none
`include "assert_macros.svh"
module u2u_decode
  import u2u_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     item_valid,
  input  wire in_item_t item,
  input  wire logic     out_free,
  output dec_res_t      res
);

  logic [1:0]  bytes_pending_r, bytes_pending_nxt;
  logic [15:0] partial_value_r, partial_value_nxt;
  logic        sequence_bad_r, sequence_bad_nxt;
  logic        string_stopped_r, string_stopped_nxt;

  logic        has_result;
  out_item_t   result;
  logic        take;
  logic [7:0]  b;
  logic        eos;
  logic        cont_ok;

  assign b       = item.data_byte;
  assign eos     = item.end_of_string;
  assign cont_ok = (b >= CONT_MIN) && (b <= CONT_MAX);

  always_comb begin
    bytes_pending_nxt  = bytes_pending_r;
    partial_value_nxt  = partial_value_r;
    sequence_bad_nxt   = sequence_bad_r;
    string_stopped_nxt = string_stopped_r;
    has_result         = 1'b0;
    result.code_unit   = REPL_WIDE;
    result.malformed   = 1'b1;

    if (string_stopped_r) begin
      // Bytes after a NUL are dropped; the end marker clears below.
    end else if (bytes_pending_r == 2'd0) begin
      priority if (b == NUL_BYTE) begin
        string_stopped_nxt = 1'b1;
      end else if (b < CONT_MIN) begin
        has_result       = 1'b1;
        result.code_unit = {8'h00, b};
        result.malformed = 1'b0;
      end else if (b < LEAD2_MIN) begin
        has_result       = 1'b1;
        result.code_unit = REPL_ASCII;
      end else if (b < LEAD3_MIN) begin
        bytes_pending_nxt = 2'd1;
        partial_value_nxt = {5'b0, b[4:0], 6'b0};
        sequence_bad_nxt  = 1'b0;
      end else if (b < LEAD4_MIN) begin
        bytes_pending_nxt = 2'd2;
        partial_value_nxt = {b[3:0], 12'b0};
        sequence_bad_nxt  = 1'b0;
      end else begin
        bytes_pending_nxt = 2'd2;
        partial_value_nxt = '0;
        sequence_bad_nxt  = 1'b1;
      end
      // A lead byte that is also the last byte is a cut-short sequence.
      if (bytes_pending_nxt != 2'd0 && eos) begin
        has_result       = 1'b1;
        result.code_unit = REPL_WIDE;
        result.malformed = 1'b1;
      end
    end else begin
      if (!cont_ok) begin
        sequence_bad_nxt = 1'b1;
      end else if (bytes_pending_r >= 2'd2) begin
        partial_value_nxt = partial_value_r | {4'b0, b[5:0], 6'b0};
      end else begin
        partial_value_nxt = partial_value_r | {10'b0, b[5:0]};
      end
      bytes_pending_nxt = bytes_pending_r - 2'd1;
      if (bytes_pending_nxt == 2'd0) begin
        has_result       = 1'b1;
        result.code_unit = sequence_bad_nxt ? REPL_WIDE : partial_value_nxt;
        result.malformed = sequence_bad_nxt;
        partial_value_nxt = '0;
        sequence_bad_nxt  = 1'b0;
      end else if (eos) begin
        has_result       = 1'b1;
        result.code_unit = REPL_WIDE;
        result.malformed = 1'b1;
      end
    end

    if (eos) begin
      bytes_pending_nxt  = 2'd0;
      partial_value_nxt  = '0;
      sequence_bad_nxt   = 1'b0;
      string_stopped_nxt = 1'b0;
    end
  end

  // A byte that yields nothing never waits for the output register.
  assign take = item_valid && (out_free || !has_result);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_pending_r  <= 2'd0;
      partial_value_r  <= '0;
      sequence_bad_r   <= 1'b0;
      string_stopped_r <= 1'b0;
    end else if (take) begin
      bytes_pending_r  <= bytes_pending_nxt;
      partial_value_r  <= partial_value_nxt;
      sequence_bad_r   <= sequence_bad_nxt;
      string_stopped_r <= string_stopped_nxt;
    end
  end

  assign res.take       = take;
  assign res.has_result = has_result;
  assign res.item       = result;

  `U2U_ASSERT(a_eos_idle,
              take && eos |=> bytes_pending_r == 2'd0 && !string_stopped_r && !sequence_bad_r,
              "state not idle after end of string")
  `U2U_ASSERT(a_stop_no_pend,
              string_stopped_r |-> bytes_pending_r == 2'd0 && partial_value_r == 16'h0000,
              "stopped string with a sequence open")
  `U2U_ASSERT(a_stop_silent, string_stopped_r |-> !has_result, "result produced after NUL")
  `U2U_ASSERT_RST(a_reset_clear,
                  !rst_n |=> bytes_pending_r == 2'd0 && !string_stopped_r && !sequence_bad_r,
                  "decoder state not cleared by reset")

endmodule
`default_nettype wire

>>> sv/u2u_out_stage.sv
// Result register that holds one code unit until the sink takes it.
`default_nettype none
module u2u_out_stage
  import u2u_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dec_res_t res,
  input  wire logic     dst_ready,
  output logic          out_free,
  output logic          dst_valid,
  output out_item_t     dst_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;
  logic      load;

  assign out_free = !valid_r || dst_ready;
  assign load     = res.take && res.has_result;

  always_comb begin
    valid_nxt = valid_r && !dst_ready;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = 1'b1;
      item_nxt  = res.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign dst_valid = valid_r;
  assign dst_item  = item_r;

endmodule
`default_nettype wire

>>> dv/utf8_to_utf16_stream_decoder_core_tb.sv
// Self-checking testbench of the UTF-8 to UTF-16 stream decoder: byte stimulus and unit checks.
import u2u_pkg::*;

// Tracks the decoder state, predicts the code unit, if any, of every accepted byte and checks results.
class utf16_unit_board;
  logic [1:0]  cont_left;
  logic [15:0] gathered;
  logic        seq_bad;
  logic        halted;
  out_item_t   units_due[$];
  int          n_bytes;
  int          n_checked;
  int          n_flagged;
  int          n_mismatch;

  function new();
    clear_state();
    n_bytes = 0;
    n_checked = 0;
    n_flagged = 0;
    n_mismatch = 0;
  endfunction

  function void clear_state();
    cont_left = 2'd0;
    gathered = 16'h0000;
    seq_bad = 1'b0;
    halted = 1'b0;
  endfunction

  function int pending();
    return units_due.size();
  endfunction

  function void note_byte(in_item_t it);
    logic [7:0] b;
    logic       has_unit;
    out_item_t  unit;
    b = it.data_byte;
    has_unit = 1'b0;
    unit = '0;
    n_bytes++;
    if (halted) begin
      // After a NUL only the end marker matters.
      if (it.end_of_string) clear_state();
      return;
    end
    if (cont_left == 2'd0) begin
      if (b == NUL_BYTE) begin
        halted = 1'b1;
      end else if (b < CONT_MIN) begin
        has_unit = 1'b1;
        unit.code_unit = {8'h00, b};
      end else if (b <= CONT_MAX) begin
        has_unit = 1'b1;
        unit.code_unit = REPL_ASCII;
        unit.malformed = 1'b1;
      end else if (b < LEAD3_MIN) begin
        cont_left = 2'd1;
        gathered = {5'b0, b[4:0], 6'b0};
        seq_bad = 1'b0;
      end else if (b < LEAD4_MIN) begin
        cont_left = 2'd2;
        gathered = {b[3:0], 12'b0};
        seq_bad = 1'b0;
      end else begin
        cont_left = 2'd2;
        gathered = 16'h0000;
        seq_bad = 1'b1;
      end
      if (cont_left != 2'd0 && it.end_of_string) begin
        has_unit = 1'b1;
        unit.code_unit = REPL_WIDE;
        unit.malformed = 1'b1;
      end
    end else begin
      if (b < CONT_MIN || b > CONT_MAX) begin
        seq_bad = 1'b1;
      end else if (cont_left == 2'd2) begin
        gathered = gathered | {4'b0, b[5:0], 6'b0};
      end else begin
        gathered = gathered | {10'b0, b[5:0]};
      end
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        has_unit = 1'b1;
        unit.code_unit = seq_bad ? REPL_WIDE : gathered;
        unit.malformed = seq_bad;
        gathered = 16'h0000;
        seq_bad = 1'b0;
      end else if (it.end_of_string) begin
        has_unit = 1'b1;
        unit.code_unit = REPL_WIDE;
        unit.malformed = 1'b1;
      end
    end
    if (it.end_of_string) clear_state();
    if (has_unit) units_due.push_back(unit);
  endfunction

  function void check_unit(out_item_t got);
    out_item_t want;
    n_checked++;
    if (got.malformed) n_flagged++;
    if (units_due.size() == 0) begin
      if (n_mismatch < 10)
        $display("unexpected code unit %h malformed=%0b with nothing pending",
                 got.code_unit, got.malformed);
      n_mismatch++;
      return;
    end
    want = units_due.pop_front();
    if (got.code_unit !== want.code_unit || got.malformed !== want.malformed) begin
      if (n_mismatch < 10)
        $display("code unit mismatch: expected %h malformed=%0b, got %h malformed=%0b",
                 want.code_unit, want.malformed, got.code_unit, got.malformed);
      n_mismatch++;
    end
  endfunction
endclass

module utf8_to_utf16_stream_decoder_core_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1450;
  localparam int LONG_HOLD    = 300;

  typedef logic [7:0] byte_seq_t[$];

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_PERIODIC,
    RX_MOSTLY
  } rx_mode_e;

  typedef enum int {
    SEQ_ASCII,
    SEQ_TWO,
    SEQ_THREE,
    SEQ_WIDE_LEAD,
    SEQ_BAD_CONT,
    SEQ_STRAY
  } seq_kind_e;

  logic clk;
  logic rst_n;
  logic hold_token;

  u2u_in_if  in_ch();
  u2u_out_if out_ch();

  utf8_to_utf16_stream_decoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf16_unit_board units;
  int              cycle_count;
  int              burst_left;
  int              random_bytes;
  int              strings_sent;
  rx_mode_e        rx_mode;
  int              rx_mode_left;
  int              rx_phase;
  int              rx_hold_left;
  logic            rx_token_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d code units still pending",
               cycle_count, units.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Both channels are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    in_item_t  seen_in;
    out_item_t seen_out;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_in.data_byte = in_ch.data_byte;
        seen_in.end_of_string = in_ch.end_of_string;
        units.note_byte(seen_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_out.code_unit = out_ch.code_unit;
        seen_out.malformed = out_ch.malformed;
        units.check_unit(seen_out);
      end
    end
  end

  // Receiver: switches between stall patterns, and holds off for a long stretch
  // whenever the stimulus flips hold_token.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode = RX_FREE;
      rx_mode_left = 0;
      rx_phase = 0;
      rx_hold_left = 0;
      rx_token_seen = hold_token;
    end else begin
      if (hold_token != rx_token_seen) begin
        rx_token_seen = hold_token;
        rx_hold_left = LONG_HOLD;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(64, 256);
        rx_phase = 0;
      end
      rx_mode_left--;
      rx_phase++;
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:     out_ch.ready <= 1'b1;
          RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ch.ready <= (rx_phase % 7) < 4;
          default:     out_ch.ready <= $urandom_range(0, 3) != 0;
        endcase
      end
    end
  end

  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // Offers one byte and returns at the edge where it is transferred.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= 8'($urandom);
        in_ch.end_of_string <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic send_bytes(input byte_seq_t seq, input logic eos_last);
    for (int k = 0; k < seq.size(); k++)
      send_byte(seq[k], eos_last && k == seq.size() - 1);
  endtask

  // Stops offering bytes until every predicted code unit has been transferred.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (units.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // One random string: mostly well-formed sequences, with bad continuations,
  // stray bytes, cut-off ends, early NULs and some plain noise mixed in.
  task automatic send_string();
    byte_seq_t seq;
    seq_kind_e kind;
    int        roll;
    int        base;
    int        pos;
    int        cut;
    int        counted;
    int        n_noise;
    logic      eos_last;
    strings_sent++;
    if ($urandom_range(0, 11) == 0) begin
      n_noise = $urandom_range(1, 12);
      for (int k = 0; k < n_noise; k++)
        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      random_bytes += n_noise;
      return;
    end
    repeat ($urandom_range(1, 8)) begin
      roll = $urandom_range(0, 99);
      kind = roll < 25 ? SEQ_ASCII : roll < 45 ? SEQ_TWO : roll < 65 ? SEQ_THREE :
             roll < 73 ? SEQ_WIDE_LEAD : roll < 88 ? SEQ_BAD_CONT : SEQ_STRAY;
      base = seq.size();
      case (kind)
        SEQ_ASCII: seq.push_back(8'($urandom_range(1, 8'h7F)));
        SEQ_TWO: begin
          seq.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          seq.push_back(rand_cont());
        end
        SEQ_THREE: begin
          seq.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          seq.push_back(rand_cont());
          seq.push_back(rand_cont());
        end
        SEQ_WIDE_LEAD: begin
          seq.push_back(8'($urandom_range(8'hF0, 8'hFF)));
          seq.push_back(8'($urandom));
          seq.push_back(8'($urandom));
        end
        SEQ_BAD_CONT: begin
          if ($urandom_range(0, 1) == 0) begin
            seq.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            seq.push_back(rand_cont());
          end else begin
            seq.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            seq.push_back(rand_cont());
            seq.push_back(rand_cont());
          end
          pos = base + $urandom_range(1, seq.size() - base - 1);
          seq[pos] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8'h7F))
                                                 : 8'($urandom_range(8'hC0, 8'hFF));
        end
        default: seq.push_back(rand_cont());
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, seq.size());
      while (seq.size() > cut) void'(seq.pop_back());
    end
    counted = seq.size();
    if ($urandom_range(0, 9) == 0) begin
      // Bytes after the NUL are only skipped, so they are not counted.
      seq.push_back(NUL_BYTE);
      counted = seq.size();
      repeat ($urandom_range(0, 4)) seq.push_back(8'($urandom));
    end
    eos_last = $urandom_range(0, 9) != 0;
    send_bytes(seq, eos_last);
    random_bytes += counted;
  endtask

  initial begin
    logic hold_done;
    logic pause_done;
    units = new();
    cycle_count = 0;
    burst_left = 0;
    random_bytes = 0;
    strings_sent = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst_n = 1'b0;
    hold_token = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_string = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ASCII and stray extremes, two- and three-byte extremes, a wide lead,
    // bad continuations, cut-off sequences and NUL handling.
    send_bytes('{8'h01, 8'h7F, 8'h80, 8'hBF}, 1'b0);
    send_bytes('{8'hC0, 8'h80, 8'hDF, 8'hBF}, 1'b0);
    send_bytes('{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF}, 1'b0);
    send_bytes('{8'hFF, 8'h00, 8'hFF}, 1'b0);
    send_bytes('{8'hC2, 8'h41, 8'hE2, 8'h82, 8'hC0}, 1'b0);
    send_bytes('{8'hC3}, 1'b1);
    send_bytes('{8'hE2, 8'h82}, 1'b1);
    send_bytes('{8'h00, 8'h41, 8'hE2, 8'h42}, 1'b1);
    send_bytes('{8'h00}, 1'b1);
    send_bytes('{8'h41}, 1'b1);
    drain();

    while (random_bytes < RANDOM_BYTES) begin
      send_string();
      if (!hold_done && random_bytes >= RANDOM_BYTES / 3) begin
        // The receiver stops for a long stretch while bytes keep coming.
        hold_token <= ~hold_token;
        hold_done = 1'b1;
      end
      if (!pause_done && random_bytes >= (2 * RANDOM_BYTES) / 3) begin
        drain();
        pause_done = 1'b1;
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("covered %0d bytes in %0d random strings plus directed cases", units.n_bytes,
             strings_sent);
    $display("compared %0d code units, %0d of them replacements, %0d mismatches",
             units.n_checked, units.n_flagged, units.n_mismatch);
    if (units.n_mismatch == 0 && units.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (units.pending() != 0)
        $display("%0d predicted code units never arrived", units.pending());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
